>>> src/jaos_pkg.sv
// Shared types, codes and helpers for the job admission and offload selector.
package jaos_pkg;

   localparam int PEER_SLOTS_DEF  = 8;
   localparam int QUEUE_DEPTH_DEF = 16;

   localparam logic [2:0] CMD_ARRIVE   = 3'd0;
   localparam logic [2:0] CMD_COMPLETE = 3'd1;
   localparam logic [2:0] CMD_DIRECT   = 3'd2;
   localparam logic [2:0] CMD_RELAY    = 3'd3;
   localparam logic [2:0] CMD_TICK     = 3'd4;

   localparam logic [2:0] ACT_RUN      = 3'd0;
   localparam logic [2:0] ACT_FORWARD  = 3'd1;
   localparam logic [2:0] ACT_QUEUED   = 3'd2;
   localparam logic [2:0] ACT_DEQUEUED = 3'd3;
   localparam logic [2:0] ACT_NONE     = 3'd4;
   localparam logic [2:0] ACT_DROPPED  = 3'd5;

   localparam logic [2:0] REG_CPU_CAP   = 3'd0;
   localparam logic [2:0] REG_MEM_CAP   = 3'd1;
   localparam logic [2:0] REG_THRESHOLD = 3'd2;
   localparam logic [2:0] REG_CPU_W     = 3'd3;
   localparam logic [2:0] REG_MEM_W     = 3'd4;
   localparam logic [2:0] REG_STALE     = 3'd5;
   localparam logic [2:0] REG_OWN_ID    = 3'd6;
   localparam logic [2:0] REG_CONN_MASK = 3'd7;

   localparam logic [11:0] CPU_CAP_RST   = 12'd1000;
   localparam logic [15:0] MEM_CAP_RST   = 16'd4096;
   localparam logic [17:0] THRESHOLD_RST = 18'd42598;
   localparam logic [16:0] CPU_W_RST     = 17'd39322;
   localparam logic [16:0] MEM_W_RST     = 17'd26214;
   localparam logic [31:0] STALE_RST     = 32'd12000;
   localparam logic [3:0]  OWN_ID_RST    = 4'd1;
   localparam logic [7:0]  CONN_MASK_RST = 8'd0;
   localparam logic [15:0] LFSR_SEED     = 16'hACE1;

   localparam logic [3:0]  HOP_LIMIT = 4'd3;
   localparam logic [3:0]  HOP_MAX   = 4'd15;
   localparam logic [17:0] Q_MAX     = 18'd131072;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] job_num;
      logic [11:0] cpu_need;
      logic [15:0] mem_need;
      logic [3:0]  hops;
      logic [3:0]  from_peer;
      logic [3:0]  peer_num;
      logic [17:0] peer_load;
      logic [47:0] stamp_ms;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] job_out;
      logic [2:0]  action;
      logic [3:0]  dest_peer;
      logic [3:0]  hops_out;
      logic [17:0] load_now;
      logic [11:0] cpu_in_use_out;
      logic [15:0] mem_in_use_out;
   } rsp_payload_type;

   typedef struct packed {
      logic [31:0] job;
      logic [11:0] cpu;
      logic [15:0] mem;
   } q_entry_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DECODE, ST_SC_START, ST_SC_WAIT, ST_SC_MUL, ST_SC_SUM,
      ST_FIT_A, ST_ENQ, ST_PK_RD, ST_PK_CMP, ST_PK_END, ST_MOD_START,
      ST_MOD_WAIT, ST_PK_RAND, ST_Q_CHECK, ST_Q_FIT, ST_EXP_RD, ST_EXP_CMP,
      ST_RL_RD, ST_RL_CMP, ST_OUT
   } state_type;

   typedef enum logic [1:0] {RET_FIT_A, RET_Q_FIT, RET_OUT} ret_type;

   typedef struct packed {
      logic accept;
      logic rel_use;
      logic admit_req;
      logic enqueue;
      logic scan_clear;
      logic scan_pick;
      logic scan_expire;
      logic fwd_best;
      logic lfsr_step;
      logic mod_start;
      logic fwd_rand;
      logic pop_head;
      logic tbl_write;
      logic score_start;
      logic score_mul;
      logic score_sum;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       div_busy;
      logic       fits_req;
      logic       fits_head;
      logic       hop_hi;
      logic       best_found;
      logic       rand_zero;
      logic       q_empty;
      logic       scan_last;
      logic       out_free;
   } dp_status_type;

   function automatic logic [3:0] count8(input logic [7:0] mask);
      logic [3:0] cnt;
      cnt = 4'd0;
      for (int n = 0; n < 8; n++) begin
         cnt = cnt + {3'b0, mask[n]};
      end
      return cnt;
   endfunction

   // id of the k-th set bit, lowest first
   function automatic logic [3:0] nth_set(input logic [7:0] mask, input logic [2:0] k);
      logic [3:0] cnt;
      logic [3:0] id;
      cnt = 4'd0;
      id  = 4'd0;
      for (int n = 0; n < 8; n++) begin
         if (mask[n]) begin
            if (cnt == {1'b0, k} && id == 4'd0) begin
               id = 4'(n + 1);
            end
            cnt = cnt + 4'd1;
         end
      end
      return id;
   endfunction

endpackage

>>> src/job_admission_offload_selector.sv
// Top level of the job admission and offload selector.
//
// Usage: one request beat on req_* (job arrival, completion, direct or relayed
// peer load report, or tick) yields exactly one response beat on rsp_*, carrying
// the decision, the own load score and the committed CPU and memory.
// Registers are written through csr_* (always ready); the user must write them
// only while the block is idle, which the block itself does not enforce.
// Each load score runs two 32-step dividers side by side, then multiply and sum.
// One request is in flight at a time; req_ready is high only while idle, so the
// next request can be taken in the cycle after the previous result is loaded.
// The result sits in an output register; a stalled receiver holds the block in
// its final step and keeps req_ready low until the result can be loaded.
// Reset (synchronous) restores register defaults, clears usage, peer valid
// bits and queue count, and seeds the LFSR.
module job_admission_offload_selector import jaos_pkg::*; #(
   parameter int PEER_SLOTS  = PEER_SLOTS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [2:0]      csr_index,
   input  logic [31:0]     csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   jaos_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   jaos_dp #(
      .PEER_SLOTS  (PEER_SLOTS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

>>> src/jaos_div.sv
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
module jaos_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] num,
   input  logic [15:0] den,
   output logic        busy,
   output logic [31:0] quo,
   output logic [15:0] rem
);

   logic [31:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] den_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff;
   logic [16:0] shifted;
   logic        ge;

   assign shifted = {rem_ff, quo_ff[31]};
   assign ge      = shifted >= {1'b0, den_ff};

   always_comb begin
      rem_in = ge ? 16'(shifted - {1'b0, den_ff}) : shifted[15:0];
      quo_in = {quo_ff[30:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 5'd31;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= 16'd0;
         den_ff <= den;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

>>> src/jaos_ctrl.sv
// Sequencer for the admission selector: walks each beat through score, peer scan, table update and queue steps.
module jaos_ctrl import jaos_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   ret_type   ret_ff, ret_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= RET_OUT;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            unique case (status.op)
               CMD_ARRIVE: begin
                  state_in = ST_SC_START;
                  ret_in   = RET_FIT_A;
               end
               CMD_COMPLETE: state_in = ST_Q_CHECK;
               CMD_DIRECT, CMD_RELAY: state_in = ST_RL_RD;
               CMD_TICK: state_in = ST_EXP_RD;
               default: begin
                  state_in = ST_SC_START;
                  ret_in   = RET_OUT;
               end
            endcase
         end
         ST_SC_START: state_in = ST_SC_WAIT;
         ST_SC_WAIT: begin
            if (!status.div_busy) state_in = ST_SC_MUL;
         end
         ST_SC_MUL: state_in = ST_SC_SUM;
         ST_SC_SUM: begin
            unique case (ret_ff)
               RET_FIT_A: state_in = ST_FIT_A;
               RET_Q_FIT: state_in = ST_Q_FIT;
               RET_OUT:   state_in = ST_OUT;
               default:   state_in = ST_OUT;
            endcase
         end
         ST_FIT_A: begin
            priority if (status.fits_req) begin
               state_in = ST_SC_START;
               ret_in   = RET_OUT;
            end else if (status.hop_hi) begin
               state_in = ST_ENQ;
            end else begin
               state_in = ST_PK_RD;
            end
         end
         ST_ENQ: begin
            state_in = ST_SC_START;
            ret_in   = RET_OUT;
         end
         ST_PK_RD: state_in = ST_PK_CMP;
         ST_PK_CMP: state_in = status.scan_last ? ST_PK_END : ST_PK_RD;
         ST_PK_END: begin
            priority if (status.best_found) begin
               state_in = ST_SC_START;
               ret_in   = RET_OUT;
            end else if (status.rand_zero) begin
               state_in = ST_ENQ;
            end else begin
               state_in = ST_MOD_START;
            end
         end
         ST_MOD_START: state_in = ST_MOD_WAIT;
         ST_MOD_WAIT: begin
            if (!status.div_busy) state_in = ST_PK_RAND;
         end
         ST_PK_RAND: begin
            state_in = ST_SC_START;
            ret_in   = RET_OUT;
         end
         ST_Q_CHECK: begin
            state_in = ST_SC_START;
            ret_in   = status.q_empty ? RET_OUT : RET_Q_FIT;
         end
         ST_Q_FIT: begin
            state_in = ST_SC_START;
            ret_in   = RET_OUT;
         end
         ST_EXP_RD: state_in = ST_EXP_CMP;
         ST_EXP_CMP: state_in = status.scan_last ? ST_Q_CHECK : ST_EXP_RD;
         ST_RL_RD: state_in = ST_RL_CMP;
         ST_RL_CMP: begin
            state_in = ST_SC_START;
            ret_in   = RET_OUT;
         end
         ST_OUT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_DECODE: begin
            cmd.rel_use    = status.op == CMD_COMPLETE;
            cmd.scan_clear = status.op == CMD_TICK;
         end
         ST_SC_START: cmd.score_start = 1'b1;
         ST_SC_MUL:   cmd.score_mul = 1'b1;
         ST_SC_SUM:   cmd.score_sum = 1'b1;
         ST_FIT_A: begin
            cmd.admit_req  = status.fits_req;
            cmd.scan_clear = !status.fits_req && !status.hop_hi;
         end
         ST_ENQ:     cmd.enqueue = 1'b1;
         ST_PK_CMP:  cmd.scan_pick = 1'b1;
         ST_PK_END: begin
            cmd.fwd_best  = status.best_found;
            cmd.lfsr_step = !status.best_found && !status.rand_zero;
         end
         ST_MOD_START: cmd.mod_start = 1'b1;
         ST_PK_RAND:   cmd.fwd_rand = 1'b1;
         ST_Q_FIT:     cmd.pop_head = status.fits_head;
         ST_EXP_CMP:   cmd.scan_expire = 1'b1;
         ST_RL_CMP:    cmd.tbl_write = 1'b1;
         ST_OUT:       cmd.out_load = status.out_free;
         default: begin
         end
      endcase
   end

endmodule

>>> src/jaos_dp.sv
// Datapath: config registers, usage counters, load score, peer table, wait queue, result register.
module jaos_dp import jaos_pkg::*; #(
   parameter int PEER_SLOTS  = PEER_SLOTS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_data,
   output rsp_payload_type rsp_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  logic            csr_valid,
   input  logic [2:0]      csr_index,
   input  logic [31:0]     csr_data,
   input  dp_cmd_type      cmd,
   output dp_status_type   status
);

   localparam int PIDX_W = $clog2(PEER_SLOTS);
   localparam int QIDX_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // configuration
   logic [11:0] cpu_cap_ff;
   logic [15:0] mem_cap_ff;
   logic [17:0] thr_ff;
   logic [16:0] cpu_w_ff, mem_w_ff;
   logic [31:0] stale_ff;
   logic [3:0]  own_ff;
   logic [7:0]  conn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cpu_cap_ff <= CPU_CAP_RST;
         mem_cap_ff <= MEM_CAP_RST;
         thr_ff     <= THRESHOLD_RST;
         cpu_w_ff   <= CPU_W_RST;
         mem_w_ff   <= MEM_W_RST;
         stale_ff   <= STALE_RST;
         own_ff     <= OWN_ID_RST;
         conn_ff    <= CONN_MASK_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_CPU_CAP:   cpu_cap_ff <= csr_data[11:0];
            REG_MEM_CAP:   mem_cap_ff <= csr_data[15:0];
            REG_THRESHOLD: thr_ff     <= csr_data[17:0];
            REG_CPU_W:     cpu_w_ff   <= csr_data[16:0];
            REG_MEM_W:     mem_w_ff   <= csr_data[16:0];
            REG_STALE:     stale_ff   <= csr_data;
            REG_OWN_ID:    own_ff     <= csr_data[3:0];
            REG_CONN_MASK: conn_ff    <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // request beat
   req_payload_type req_ff;
   always_ff @(posedge clock) begin
      if (cmd.accept) req_ff <= req_data;
   end

   // wait queue
   q_entry_type         q_mem [QUEUE_DEPTH];
   q_entry_type         q_rd_ff;
   logic [QIDX_W-1:0]   head_ff, head_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QIDX_W:0]     tail_sum;
   logic [QIDX_W-1:0]   tail;
   logic                q_full, q_empty, q_we;

   assign tail_sum = (QIDX_W+1)'(head_ff) + (QIDX_W+1)'(count_ff);
   assign tail     = (tail_sum >= (QIDX_W+1)'(QUEUE_DEPTH))
                   ? QIDX_W'(tail_sum - (QIDX_W+1)'(QUEUE_DEPTH)) : tail_sum[QIDX_W-1:0];
   assign q_full   = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign q_empty  = count_ff == '0;
   assign q_we     = cmd.enqueue && !q_full;
   assign head_in  = (head_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (q_we) q_mem[tail] <= '{job: req_ff.job_num, cpu: req_ff.cpu_need,
                                 mem: req_ff.mem_need};
      q_rd_ff <= q_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (q_we) begin
         count_ff <= count_ff + 1'b1;
      end else if (cmd.pop_head) begin
         head_ff  <= head_in;
         count_ff <= count_ff - 1'b1;
      end
   end

   // usage counters
   logic [11:0] cpu_use_ff, cpu_use_in;
   logic [15:0] mem_use_ff, mem_use_in;

   always_comb begin
      cpu_use_in = cpu_use_ff;
      mem_use_in = mem_use_ff;
      priority if (cmd.rel_use) begin
         cpu_use_in = cpu_use_ff > req_ff.cpu_need ? cpu_use_ff - req_ff.cpu_need : 12'd0;
         mem_use_in = mem_use_ff > req_ff.mem_need ? mem_use_ff - req_ff.mem_need : 16'd0;
      end else if (cmd.admit_req) begin
         cpu_use_in = cpu_use_ff + req_ff.cpu_need;
         mem_use_in = mem_use_ff + req_ff.mem_need;
      end else if (cmd.pop_head) begin
         cpu_use_in = cpu_use_ff + q_rd_ff.cpu;
         mem_use_in = mem_use_ff + q_rd_ff.mem;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpu_use_ff <= '0;
         mem_use_ff <= '0;
      end else begin
         cpu_use_ff <= cpu_use_in;
         mem_use_ff <= mem_use_in;
      end
   end

   // random fallback
   logic [15:0] lfsr_ff, lfsr_in;
   logic [7:0]  elig;
   logic [3:0]  rand_cnt;

   assign lfsr_in = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5], lfsr_ff[15:1]};

   always_comb begin
      for (int n = 0; n < 8; n++) begin
         elig[n] = conn_ff[n] && 4'(n + 1) != req_ff.from_peer && 4'(n + 1) != own_ff;
      end
   end
   assign rand_cnt = count8(elig);

   always_ff @(posedge clock) begin
      if (reset) lfsr_ff <= LFSR_SEED;
      else if (cmd.lfsr_step) lfsr_ff <= lfsr_in;
   end

   // load score: two dividers, two multipliers, saturating sum
   logic [31:0] quo_c, quo_m;
   logic [15:0] rem_c, rem_m;
   logic        busy_c, busy_m;
   logic [31:0] num_c;
   logic [15:0] den_c;
   logic [17:0] ratio_c, ratio_m;
   logic [34:0] prod_c_ff, prod_m_ff;
   logic [35:0] prod_sum;
   logic [19:0] score_wide;
   logic [17:0] score_ff, score_in;

   assign num_c = cmd.mod_start ? {16'd0, lfsr_ff} : {4'd0, cpu_use_ff, 16'd0};
   assign den_c = cmd.mod_start ? {12'd0, rand_cnt} : {4'd0, cpu_cap_ff};

   jaos_div u_div_cpu (
      .clock (clock),
      .reset (reset),
      .start (cmd.score_start || cmd.mod_start),
      .num   (num_c),
      .den   (den_c),
      .busy  (busy_c),
      .quo   (quo_c),
      .rem   (rem_c)
   );

   jaos_div u_div_mem (
      .clock (clock),
      .reset (reset),
      .start (cmd.score_start),
      .num   ({mem_use_ff, 16'd0}),
      .den   (mem_cap_ff),
      .busy  (busy_m),
      .quo   (quo_m),
      .rem   (rem_m)
   );

   assign ratio_c = (cpu_cap_ff == '0 || quo_c > 32'(Q_MAX)) ? Q_MAX : quo_c[17:0];
   assign ratio_m = (mem_cap_ff == '0 || quo_m > 32'(Q_MAX)) ? Q_MAX : quo_m[17:0];

   always_ff @(posedge clock) begin
      if (cmd.score_mul) begin
         prod_c_ff <= {18'd0, cpu_w_ff} * {17'd0, ratio_c};
         prod_m_ff <= {18'd0, mem_w_ff} * {17'd0, ratio_m};
      end
   end

   assign prod_sum   = {1'b0, prod_c_ff} + {1'b0, prod_m_ff};
   assign score_wide = prod_sum[35:16];
   assign score_in   = (score_wide > 20'(Q_MAX)) ? Q_MAX : score_wide[17:0];

   always_ff @(posedge clock) begin
      if (reset) score_ff <= '0;
      else if (cmd.score_sum) score_ff <= score_in;
   end

   logic score_ok, fits_req, fits_head;
   assign score_ok  = score_ff < thr_ff;
   assign fits_req  = ({1'b0, cpu_use_ff} + {1'b0, req_ff.cpu_need}) <= {1'b0, cpu_cap_ff}
                   && ({1'b0, mem_use_ff} + {1'b0, req_ff.mem_need}) <= {1'b0, mem_cap_ff}
                   && score_ok;
   assign fits_head = ({1'b0, cpu_use_ff} + {1'b0, q_rd_ff.cpu}) <= {1'b0, cpu_cap_ff}
                   && ({1'b0, mem_use_ff} + {1'b0, q_rd_ff.mem}) <= {1'b0, mem_cap_ff}
                   && score_ok;

   // peer table
   logic [17:0]       tbl_load_mem  [PEER_SLOTS];
   logic [47:0]       tbl_stamp_mem [PEER_SLOTS];
   logic [17:0]       tbl_load_ff;
   logic [47:0]       tbl_stamp_ff;
   logic [PEER_SLOTS-1:0] valid_ff;
   logic [PIDX_W-1:0] scan_idx_ff, best_idx_ff, rd_addr, rep_idx;
   logic [17:0]       best_load_ff;
   logic              best_found_ff;
   logic [7:0]        rep_sub, scan_id, best_id;
   logic              rep_in_range, is_report, tbl_we, scan_last, pick_ok, expire_hit;

   assign rep_sub      = 8'(req_ff.peer_num) - 8'd1;
   assign rep_idx      = rep_sub[PIDX_W-1:0];
   assign rep_in_range = req_ff.peer_num != 4'd0 && 8'(req_ff.peer_num) <= 8'(PEER_SLOTS);
   assign is_report    = req_ff.cmd == CMD_DIRECT || req_ff.cmd == CMD_RELAY;
   assign rd_addr      = is_report ? rep_idx : scan_idx_ff;
   assign tbl_we       = cmd.tbl_write && rep_in_range
                      && (req_ff.cmd == CMD_DIRECT
                          || (req_ff.peer_num != own_ff
                              && (!valid_ff[rep_idx] || tbl_stamp_ff < req_ff.stamp_ms)));

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_load_mem[rep_idx]  <= req_ff.peer_load;
         tbl_stamp_mem[rep_idx] <= req_ff.stamp_ms;
      end
      tbl_load_ff  <= tbl_load_mem[rd_addr];
      tbl_stamp_ff <= tbl_stamp_mem[rd_addr];
   end

   assign scan_id    = 8'(scan_idx_ff) + 8'd1;
   assign best_id    = 8'(best_idx_ff) + 8'd1;
   assign scan_last  = scan_idx_ff == PIDX_W'(PEER_SLOTS - 1);
   assign pick_ok    = valid_ff[scan_idx_ff] && scan_id != 8'(req_ff.from_peer)
                    && tbl_load_ff < thr_ff
                    && (!best_found_ff || tbl_load_ff < best_load_ff);
   assign expire_hit = valid_ff[scan_idx_ff] && req_ff.stamp_ms > tbl_stamp_ff
                    && (req_ff.stamp_ms - tbl_stamp_ff) > {16'd0, stale_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (tbl_we) begin
         valid_ff[rep_idx] <= 1'b1;
      end else if (cmd.scan_expire && expire_hit) begin
         valid_ff[scan_idx_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff   <= '0;
         best_found_ff <= 1'b0;
      end else if (cmd.scan_clear) begin
         scan_idx_ff   <= '0;
         best_found_ff <= 1'b0;
      end else if (cmd.scan_pick || cmd.scan_expire) begin
         scan_idx_ff <= scan_last ? '0 : scan_idx_ff + 1'b1;
         if (cmd.scan_pick && pick_ok) best_found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_pick && pick_ok) begin
         best_idx_ff  <= scan_idx_ff;
         best_load_ff <= tbl_load_ff;
      end
   end

   // result fields
   logic [31:0] res_job_ff;
   logic [2:0]  res_act_ff;
   logic [3:0]  res_target_ff, res_hops_ff, hops_inc;

   assign hops_inc = req_ff.hops < HOP_MAX ? req_ff.hops + 4'd1 : HOP_MAX;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         res_job_ff    <= req_data.cmd == CMD_ARRIVE ? req_data.job_num : 32'd0;
         res_act_ff    <= ACT_NONE;
         res_target_ff <= 4'd0;
         res_hops_ff   <= 4'd0;
      end else if (cmd.admit_req) begin
         res_act_ff <= ACT_RUN;
      end else if (cmd.enqueue) begin
         res_act_ff <= q_full ? ACT_DROPPED : ACT_QUEUED;
      end else if (cmd.fwd_best) begin
         res_act_ff    <= ACT_FORWARD;
         res_target_ff <= best_id[3:0];
         res_hops_ff   <= hops_inc;
      end else if (cmd.fwd_rand) begin
         res_act_ff    <= ACT_FORWARD;
         res_target_ff <= nth_set(elig, rem_c[2:0]);
         res_hops_ff   <= hops_inc;
      end else if (cmd.pop_head) begin
         res_act_ff <= ACT_DEQUEUED;
         res_job_ff <= q_rd_ff.job;
      end
   end

   // output register
   rsp_payload_type rsp_ff;
   logic            rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff <= '{job_out: res_job_ff, action: res_act_ff, dest_peer: res_target_ff,
                     hops_out: res_hops_ff, load_now: score_ff,
                     cpu_in_use_out: cpu_use_ff, mem_in_use_out: mem_use_ff};
      end
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   assign status.op         = req_ff.cmd;
   assign status.div_busy   = busy_c || busy_m;
   assign status.fits_req   = fits_req;
   assign status.fits_head  = fits_head;
   assign status.hop_hi     = req_ff.hops >= HOP_LIMIT;
   assign status.best_found = best_found_ff;
   assign status.rand_zero  = rand_cnt == 4'd0;
   assign status.q_empty    = q_empty;
   assign status.scan_last  = scan_last;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

endmodule
